>>> sv/mnph_pkg.sv
`timescale 1ns / 1ps

package mnph_pkg;

    // Field widths: note and channel fixed by the MIDI message format
    localparam int NOTE_W   = 7;
    localparam int CHAN_W   = 4;
    localparam int COUNT_W  = 8;
    localparam int VOICE_W  = 16;

    // Held-count store: one entry per channel and note
    localparam int COUNT_AW    = CHAN_W + NOTE_W;
    localparam int COUNT_DEPTH = 1 << COUNT_AW;

    localparam int DEF_STACK_DEPTH = 8;

    localparam logic [CHAN_W-1:0]  DRUM_CHANNEL = 4'd9;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;
    localparam logic [VOICE_W-1:0] VOICES_MAX   = 16'hFFFF;

    // Request command codes
    localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [1:0] CMD_ALL_OFF  = 2'd2;

    // Result kinds
    localparam logic [1:0] EV_TRIGGER = 2'd0;
    localparam logic [1:0] EV_RELEASE = 2'd1;
    localparam logic [1:0] EV_GLIDE   = 2'd2;
    localparam logic [1:0] EV_ALL_OFF = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [CHAN_W-1:0] channel;
        logic [NOTE_W-1:0] note_number;
        logic [NOTE_W-1:0] velocity;
    } note_req_t;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic               drum_target;
        logic [NOTE_W-1:0]  event_note;
        logic [NOTE_W-1:0]  event_velocity;
        logic [VOICE_W-1:0] voice_count;
    } note_event_t;

    typedef enum logic [1:0] {
        STK_MOVE_TOP = 2'd0,
        STK_REMOVE   = 2'd1,
        STK_FLUSH    = 2'd2
    } stk_op_t;

    typedef struct packed {
        logic              apply;
        stk_op_t           op;
        logic [NOTE_W-1:0] note;
    } stk_ctrl_t;

    typedef struct packed {
        logic              found;
        logic              was_top;
        logic              empty_after;
        logic              one_after;
        logic [NOTE_W-1:0] top_note;
    } stk_stat_t;

endpackage

>>> sv/mnph_ram.sv
`timescale 1ns / 1ps

module mnph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/mnph_stack.sv
`timescale 1ns / 1ps

module mnph_stack
    import mnph_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  stk_ctrl_t ctrl,
    output stk_stat_t stat
);

    localparam int FW = $clog2(STACK_DEPTH + 1);

    logic [NOTE_W-1:0] stack_reg  [STACK_DEPTH];
    logic [NOTE_W-1:0] stack_next [STACK_DEPTH];
    logic [FW-1:0]     fill_reg;
    logic [FW-1:0]     fill_next;

    logic [STACK_DEPTH-1:0] hit;
    logic                   found;
    logic [FW-1:0]          pos;
    logic [FW-1:0]          fill_rm;
    logic [FW-1:0]          fill_push;
    logic [FW-1:0]          below_top;
    logic [NOTE_W-1:0]      top_note;
    logic [NOTE_W-1:0]      removed [STACK_DEPTH];
    logic [NOTE_W-1:0]      pushed  [STACK_DEPTH];

    always_comb
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            hit[i] = (FW'(i) < fill_reg) && (stack_reg[i] == ctrl.note);
        end
        found = |hit;

        // Lowest matching entry
        pos = '0;
        for (int i = STACK_DEPTH - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                pos = FW'(i);
            end
        end

        // Close the gap left by the matching entry
        for (int i = 0; i < STACK_DEPTH - 1; i++)
        begin
            removed[i] = (found && FW'(i) >= pos) ? stack_reg[i + 1] : stack_reg[i];
        end
        removed[STACK_DEPTH-1] = stack_reg[STACK_DEPTH-1];
        fill_rm = found ? fill_reg - FW'(1) : fill_reg;

        // Place the note on top if there is room
        pushed    = removed;
        fill_push = fill_rm;
        if (fill_rm < FW'(STACK_DEPTH))
        begin
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                if (FW'(i) == fill_rm)
                begin
                    pushed[i] = ctrl.note;
                end
            end
            fill_push = fill_rm + FW'(1);
        end

        // Entry that becomes the top once the top is removed
        below_top = fill_reg - FW'(2);
        top_note  = '0;
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            if (FW'(i) == below_top)
            begin
                top_note = stack_reg[i];
            end
        end

        stat.found       = found;
        stat.was_top     = found && (pos == fill_reg - FW'(1));
        stat.empty_after = (fill_rm == '0);
        stat.one_after   = (fill_push == FW'(1));
        stat.top_note    = top_note;

        stack_next = stack_reg;
        fill_next  = fill_reg;
        if (ctrl.apply)
        begin
            case (ctrl.op)
                STK_MOVE_TOP:
                begin
                    stack_next = pushed;
                    fill_next  = fill_push;
                end
                STK_REMOVE:
                begin
                    stack_next = removed;
                    fill_next  = fill_rm;
                end
                STK_FLUSH:
                begin
                    fill_next = '0;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stack_reg <= stack_next;
    end

endmodule

>>> sv/midi_note_priority_handler.sv
`timescale 1ns / 1ps
// A request is taken in ST_IDLE, where the held-count RAM read starts; in ST_EXEC the count is
//   read-modified-written and any result loads the output register, once the previous one is taken.
// Requests are taken one at a time: a new one is accepted only once the block is back in ST_IDLE.
// Reset clears control state, then sweeps the 2048-entry held-count RAM to zero
//   (no requests taken); all-notes-off starts the same sweep.
module midi_note_priority_handler
    import mnph_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // Note requests
    input  logic        note_valid,
    output logic        note_ready,
    input  note_req_t   note_req,
    // Engine events
    output logic        event_valid,
    input  logic        event_ready,
    output note_event_t event_rsp,
    // Mode register write
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [COUNT_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    note_req_t            req_reg;
    logic                 mode_reg;
    logic [VOICE_W-1:0]   voices_reg, voices_next;
    logic                 out_valid_reg, out_valid_next;
    note_event_t          out_data_reg, out_data_next;

    // Held-count RAM ports
    logic                 ram_wr_en;
    logic [COUNT_AW-1:0]  ram_wr_addr;
    logic [COUNT_W-1:0]   ram_wr_data;
    logic                 ram_rd_en;
    logic [COUNT_W-1:0]   held_cnt;

    stk_ctrl_t            stk_ctrl;
    stk_stat_t            stk_stat;

    logic                 exec_go;
    logic                 is_on;
    logic                 is_off;
    logic                 is_drum;
    logic                 emit;
    note_event_t          ev;

    assign note_ready  = (state_reg == ST_IDLE);
    assign event_valid = out_valid_reg;
    assign event_rsp   = out_data_reg;

    // Start the count read as the request is taken
    assign ram_rd_en = note_valid && note_ready;

    mnph_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (COUNT_DEPTH)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr ({note_req.channel, note_req.note_number}),
        .rd_data (held_cnt)
    );

    mnph_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (stk_ctrl),
        .stat  (stk_stat)
    );

    always_comb
    begin
        // Hold execution while an earlier result still waits downstream
        exec_go = !out_valid_reg || event_ready;

        is_on   = (req_reg.command == CMD_NOTE_ON) && (req_reg.velocity != '0);
        is_off  = (req_reg.command == CMD_NOTE_OFF) ||
                  ((req_reg.command == CMD_NOTE_ON) && (req_reg.velocity == '0));
        is_drum = (req_reg.channel == DRUM_CHANNEL);

        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        voices_next  = voices_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = {req_reg.channel, req_reg.note_number};
        ram_wr_data = held_cnt;

        stk_ctrl.apply = 1'b0;
        stk_ctrl.op    = STK_MOVE_TOP;
        stk_ctrl.note  = req_reg.note_number;

        emit              = 1'b0;
        ev.event_kind     = EV_TRIGGER;
        ev.drum_target    = 1'b0;
        ev.event_note     = req_reg.note_number;
        ev.event_velocity = '0;
        ev.voice_count    = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the count RAM one entry a cycle
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + COUNT_AW'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (note_valid)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                    if (req_reg.command == CMD_ALL_OFF)
                    begin
                        // Drop every held note, then sweep the counts
                        voices_next    = '0;
                        stk_ctrl.apply = 1'b1;
                        stk_ctrl.op    = STK_FLUSH;
                        emit           = 1'b1;
                        ev.event_kind  = EV_ALL_OFF;
                        ev.event_note  = '0;
                        clr_cnt_next   = '0;
                        state_next     = ST_CLEAR;
                    end
                    else if (is_on)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = (held_cnt == COUNT_MAX) ? COUNT_MAX
                                                              : held_cnt + COUNT_W'(1);
                        emit              = 1'b1;
                        ev.event_velocity = req_reg.velocity;
                        if (is_drum)
                        begin
                            ev.drum_target = 1'b1;
                            if (voices_reg != VOICES_MAX)
                            begin
                                voices_next = voices_reg + VOICE_W'(1);
                            end
                        end
                        else if (mode_reg)
                        begin
                            // Move the note to the top; only a lone note retriggers
                            stk_ctrl.apply = 1'b1;
                            stk_ctrl.op    = STK_MOVE_TOP;
                            voices_next    = VOICE_W'(1);
                            if (!stk_stat.one_after)
                            begin
                                ev.event_kind     = EV_GLIDE;
                                ev.event_velocity = '0;
                            end
                        end
                        else if (voices_reg != VOICES_MAX)
                        begin
                            voices_next = voices_reg + VOICE_W'(1);
                        end
                    end
                    else if (is_off && (held_cnt != '0))
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = held_cnt - COUNT_W'(1);
                        ev.event_kind = EV_RELEASE;
                        if (is_drum)
                        begin
                            emit           = 1'b1;
                            ev.drum_target = 1'b1;
                            if (voices_reg != '0)
                            begin
                                voices_next = voices_reg - VOICE_W'(1);
                            end
                        end
                        else if (mode_reg)
                        begin
                            if (stk_stat.found)
                            begin
                                stk_ctrl.apply = 1'b1;
                                stk_ctrl.op    = STK_REMOVE;
                                if (stk_stat.empty_after)
                                begin
                                    voices_next = '0;
                                    emit        = 1'b1;
                                end
                                else if (stk_stat.was_top)
                                begin
                                    // Glide back to the note underneath
                                    emit          = 1'b1;
                                    ev.event_kind = EV_GLIDE;
                                    ev.event_note = stk_stat.top_note;
                                end
                            end
                        end
                        else
                        begin
                            emit = 1'b1;
                            if (voices_reg != '0)
                            begin
                                voices_next = voices_reg - VOICE_W'(1);
                            end
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        ev.voice_count = voices_next;

        // Output register: advance when taken, load a fresh result whenever execution emits one
        out_valid_next = out_valid_reg && !event_ready;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            mode_reg      <= 1'b0;
            voices_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            voices_reg    <= voices_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (note_valid && note_ready)
        begin
            req_reg <= note_req;
        end
    end

endmodule

>>> dv/midi_note_priority_handler_test.sv
`timescale 1ns / 1ps

module midi_note_priority_handler_test;
    import mnph_pkg::*;

    // Command code 3 has no name in the package: the block must ignore it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int STACK_N       = DEF_STACK_DEPTH;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX    = 10;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        note_valid;
    logic        note_ready;
    note_req_t   note_req;
    logic        event_valid;
    logic        event_ready = 1'b0;
    note_event_t event_rsp;
    logic        cfg_wr_en;
    logic        cfg_wr_data;

    midi_note_priority_handler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .note_valid  (note_valid),
        .note_ready  (note_ready),
        .note_req    (note_req),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .event_rsp   (event_rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: held counts, mono note stack, voice estimate
    // and the mode bit, updated as each request is accepted.
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] held_cnt [0:COUNT_DEPTH-1];
    logic [NOTE_W-1:0]  mono_stack [0:STACK_N-1];
    int                 stack_used;
    logic [VOICE_W-1:0] voices;
    logic               mono_on;

    note_event_t pending_events [$];   // engine events still owed by the block
    logic [10:0] held_keys [$];        // channel and note pairs the stimulus thinks are held

    int  fault_count     = 0;
    int  events_checked  = 0;
    int  requests_sent   = 0;
    int  cycle_count     = 0;
    int  stall_left      = 0;
    bit  bursts_on       = 1'b1;

    function automatic note_req_t make_req(input logic [1:0] cmd, input logic [CHAN_W-1:0] ch,
                                           input logic [NOTE_W-1:0] nn,
                                           input logic [NOTE_W-1:0] vel);
        note_req_t r;
        r.command     = cmd;
        r.channel     = ch;
        r.note_number = nn;
        r.velocity    = vel;
        return r;
    endfunction

    // The voice estimate is taken as it stands after the step has updated it
    function automatic note_event_t make_event(input logic [1:0] kind, input logic drum,
                                               input logic [NOTE_W-1:0] nn,
                                               input logic [NOTE_W-1:0] vel);
        note_event_t ev;
        ev.event_kind     = kind;
        ev.drum_target    = drum;
        ev.event_note     = nn;
        ev.event_velocity = vel;
        ev.voice_count    = voices;
        return ev;
    endfunction

    function automatic int stack_locate(input logic [NOTE_W-1:0] nn);
        for (int i = 0; i < stack_used; i++)
        begin
            if (mono_stack[i] == nn)
                return i;
        end
        return -1;
    endfunction

    // Close the gap left by the entry at pos
    function automatic void stack_drop(input int pos);
        for (int i = pos; i + 1 < stack_used; i++)
            mono_stack[i] = mono_stack[i + 1];
        if (stack_used > 0)
            stack_used--;
    endfunction

    function automatic bit release_note(input logic [CHAN_W-1:0] ch,
                                        input logic [NOTE_W-1:0] nn,
                                        output note_event_t ev);
        logic [COUNT_AW-1:0] idx;
        int                  pos;
        bit                  was_top;
        idx = {ch, nn};
        ev  = '0;
        // Drop releases of notes that are not held
        if (held_cnt[idx] == 0)
            return 1'b0;
        held_cnt[idx]--;
        if (ch == DRUM_CHANNEL)
        begin
            if (voices != 0)
                voices--;
            ev = make_event(EV_RELEASE, 1'b1, nn, '0);
            return 1'b1;
        end
        if (mono_on)
        begin
            pos = stack_locate(nn);
            // Count goes down, but a note missing from the stack says nothing
            if (pos < 0)
                return 1'b0;
            was_top = (pos + 1 == stack_used);
            stack_drop(pos);
            if (stack_used == 0)
            begin
                voices = '0;
                ev = make_event(EV_RELEASE, 1'b0, nn, '0);
                return 1'b1;
            end
            if (was_top)
            begin
                ev = make_event(EV_GLIDE, 1'b0, mono_stack[stack_used - 1], '0);
                return 1'b1;
            end
            return 1'b0;
        end
        if (voices != 0)
            voices--;
        ev = make_event(EV_RELEASE, 1'b0, nn, '0);
        return 1'b1;
    endfunction

    // Work out the event, if any, that one accepted request must produce
    function automatic bit predict_event(input note_req_t r, output note_event_t ev);
        logic [COUNT_AW-1:0] idx;
        int                  pos;
        idx = {r.channel, r.note_number};
        ev  = '0;
        case (r.command)
            CMD_NOTE_OFF:
                return release_note(r.channel, r.note_number, ev);
            CMD_ALL_OFF:
            begin
                for (int i = 0; i < COUNT_DEPTH; i++)
                    held_cnt[i] = '0;
                voices     = '0;
                stack_used = 0;
                ev = make_event(EV_ALL_OFF, 1'b0, '0, '0);
                return 1'b1;
            end
            CMD_NOTE_ON:
            begin
                // Velocity zero is a release in disguise
                if (r.velocity == 0)
                    return release_note(r.channel, r.note_number, ev);
                if (held_cnt[idx] != COUNT_MAX)
                    held_cnt[idx]++;
                if (r.channel == DRUM_CHANNEL)
                begin
                    if (voices != VOICES_MAX)
                        voices++;
                    ev = make_event(EV_TRIGGER, 1'b1, r.note_number, r.velocity);
                    return 1'b1;
                end
                if (mono_on)
                begin
                    // Move a repeated note to the top; a full stack still glides
                    pos = stack_locate(r.note_number);
                    if (pos >= 0)
                        stack_drop(pos);
                    if (stack_used < STACK_N)
                    begin
                        mono_stack[stack_used] = r.note_number;
                        stack_used++;
                    end
                    voices = 16'd1;
                    if (stack_used == 1)
                        ev = make_event(EV_TRIGGER, 1'b0, r.note_number, r.velocity);
                    else
                        ev = make_event(EV_GLIDE, 1'b0, r.note_number, '0);
                    return 1'b1;
                end
                if (voices != VOICES_MAX)
                    voices++;
                ev = make_event(EV_TRIGGER, 1'b0, r.note_number, r.velocity);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side. Every call starts at a rising edge and returns at the
    // edge of acceptance with valid still high, so a following request
    // can go out in the same step without valid dropping in between.
    // ------------------------------------------------------------------
    task automatic send_request(input note_req_t req);
        note_event_t ev;
        int          gap;
        if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            note_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        note_valid <= 1'b1;
        note_req   <= req;
        do
            @(posedge clk);
        while (!note_ready);
        requests_sent++;
        if (predict_event(req, ev))
            pending_events.push_back(ev);
    endtask

    // Drop valid and wait for the block to go quiet
    task automatic settle();
        int waited;
        waited = 0;
        note_valid <= 1'b0;
        while (pending_events.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only ever called between requests, though the block may still be sweeping its counts; never twice in a row
    task automatic write_mode(input logic mono);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mono;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mono_on = mono;
    endtask

    // ------------------------------------------------------------------
    // Event side: stall in random bursts, check every accepted event
    // against the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left  <= stall_left - 1;
            event_ready <= (stall_left == 1);
        end
        else if (bursts_on && $urandom_range(0, 9) == 0)
        begin
            stall_left  <= $urandom_range(1, 18);
            event_ready <= 1'b0;
        end
        else
            event_ready <= 1'b1;
    end

    task automatic log_fault(input string why, input note_event_t want, input note_event_t got);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("%0t %s: want kind=%0d drum=%0d note=%0d vel=%0d voices=%0d",
                     $time, why, want.event_kind, want.drum_target, want.event_note,
                     want.event_velocity, want.voice_count);
        if (fault_count <= REPORT_MAX)
            $display("    got kind=%0d drum=%0d note=%0d vel=%0d voices=%0d",
                     got.event_kind, got.drum_target, got.event_note,
                     got.event_velocity, got.voice_count);
    endtask

    always @(posedge clk)
    begin
        note_event_t want;
        if (rst_n && event_valid && event_ready)
        begin
            if (pending_events.size() == 0)
                log_fault("event with nothing owed", '0, event_rsp);
            else
            begin
                want = pending_events.pop_front();
                events_checked++;
                if (event_rsp.event_kind !== want.event_kind
                    || event_rsp.drum_target !== want.drum_target
                    || event_rsp.event_note !== want.event_note
                    || event_rsp.event_velocity !== want.event_velocity
                    || event_rsp.voice_count !== want.voice_count)
                    log_fault("event mismatch", want, event_rsp);
            end
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Hard stop if the block hangs
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Polyphonic basics: field extremes, drum routing, velocity zero as a
    // release, a release of a note not held, the unused command, all-off
    task automatic test_poly_basics();
        send_request(make_req(CMD_NOTE_ON, 4'd0, 7'd0, 7'd127));
        send_request(make_req(CMD_NOTE_ON, 4'd15, 7'd127, 7'd1));
        send_request(make_req(CMD_NOTE_ON, DRUM_CHANNEL, 7'd60, 7'd100));
        send_request(make_req(CMD_NOTE_OFF, DRUM_CHANNEL, 7'd60, 7'd127));
        send_request(make_req(CMD_NOTE_OFF, 4'd3, 7'd5, 7'd0));
        send_request(make_req(CMD_NOTE_ON, 4'd0, 7'd0, 7'd0));
        send_request(make_req(CMD_UNUSED, 4'd5, 7'd7, 7'd9));
        send_request(make_req(CMD_ALL_OFF, 4'd15, 7'd127, 7'd127));
        send_request(make_req(CMD_NOTE_OFF, 4'd15, 7'd127, 7'd0));
        settle();
    endtask

    // Last-note priority: trigger, glide up, release under the top, glide
    // back, re-press of a held note, a full stack, release of a note that
    // never made it onto the stack
    task automatic test_mono_priority();
        write_mode(1'b1);
        send_request(make_req(CMD_NOTE_ON, 4'd1, 7'd40, 7'd90));
        send_request(make_req(CMD_NOTE_ON, 4'd1, 7'd43, 7'd80));
        send_request(make_req(CMD_NOTE_ON, 4'd1, 7'd47, 7'd80));
        send_request(make_req(CMD_NOTE_OFF, 4'd1, 7'd43, 7'd0));
        send_request(make_req(CMD_NOTE_OFF, 4'd1, 7'd47, 7'd0));
        send_request(make_req(CMD_NOTE_ON, 4'd1, 7'd40, 7'd70));
        for (int k = 1; k <= STACK_N; k++)
            send_request(make_req(CMD_NOTE_ON, 4'd1, 7'(40 + k), 7'd50));
        send_request(make_req(CMD_NOTE_OFF, 4'd1, 7'(40 + STACK_N), 7'd0));
        send_request(make_req(CMD_NOTE_OFF, 4'd1, 7'(40 + STACK_N - 1), 7'd0));
        send_request(make_req(CMD_NOTE_OFF, 4'd1, 7'd40, 7'd0));
        send_request(make_req(CMD_ALL_OFF, 4'd0, 7'd0, 7'd0));
        settle();
    endtask

    // A mode change keeps counts and stack: hold notes in mono, release in
    // poly until the voice estimate bottoms out, then go back to mono
    task automatic test_mode_switch();
        send_request(make_req(CMD_NOTE_ON, 4'd2, 7'd50, 7'd60));
        send_request(make_req(CMD_NOTE_ON, 4'd2, 7'd52, 7'd60));
        send_request(make_req(CMD_NOTE_ON, DRUM_CHANNEL, 7'd36, 7'd99));
        settle();
        write_mode(1'b0);
        send_request(make_req(CMD_NOTE_OFF, 4'd2, 7'd50, 7'd0));
        send_request(make_req(CMD_NOTE_OFF, 4'd2, 7'd52, 7'd0));
        send_request(make_req(CMD_NOTE_OFF, DRUM_CHANNEL, 7'd36, 7'd0));
        settle();
        write_mode(1'b1);
        send_request(make_req(CMD_NOTE_ON, 4'd2, 7'd55, 7'd60));
        send_request(make_req(CMD_NOTE_ON, 4'd2, 7'd50, 7'd60));
        send_request(make_req(CMD_NOTE_OFF, 4'd2, 7'd55, 7'd0));
        send_request(make_req(CMD_NOTE_OFF, 4'd2, 7'd50, 7'd0));
        send_request(make_req(CMD_ALL_OFF, 4'd0, 7'd0, 7'd0));
        settle();
    endtask

    // Push one held count past its ceiling, then release it all the way
    task automatic test_count_ceiling();
        write_mode(1'b0);
        for (int k = 0; k < 257; k++)
            send_request(make_req(CMD_NOTE_ON, 4'd4, 7'd99, 7'd64));
        for (int k = 0; k < 256; k++)
            send_request(make_req(CMD_NOTE_OFF, 4'd4, 7'd99, 7'd0));
        send_request(make_req(CMD_ALL_OFF, 4'd0, 7'd0, 7'd0));
        settle();
    endtask

    // Mostly presses and releases of held notes on a few channels, so the
    // mono stack fills up; the rest is stray releases, velocity zero,
    // the unused command, all-off and field extremes
    function automatic note_req_t random_request();
        int                pick;
        int                slot;
        logic [CHAN_W-1:0] ch;
        logic [NOTE_W-1:0] nn;
        logic [10:0]       key;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0, 1:       ch = DRUM_CHANNEL;
            2, 3, 4, 5: ch = CHAN_W'($urandom_range(0, 1));
            default:    ch = CHAN_W'($urandom_range(0, 15));
        endcase
        if ($urandom_range(0, 2) != 0)
            nn = NOTE_W'(60 + $urandom_range(0, 11));
        else
            nn = NOTE_W'($urandom_range(0, 127));
        if (pick < 45)
        begin
            held_keys.push_back({ch, nn});
            return make_req(CMD_NOTE_ON, ch, nn, NOTE_W'($urandom_range(1, 127)));
        end
        if (pick < 78 && held_keys.size() != 0)
        begin
            slot = $urandom_range(0, held_keys.size() - 1);
            key  = held_keys[slot];
            held_keys.delete(slot);
            if ($urandom_range(0, 4) == 0)
                return make_req(CMD_NOTE_ON, key[10:7], key[6:0], 7'd0);
            return make_req(CMD_NOTE_OFF, key[10:7], key[6:0], NOTE_W'($urandom_range(0, 127)));
        end
        if (pick < 88)
            return make_req(CMD_NOTE_OFF, ch, nn, NOTE_W'($urandom_range(0, 127)));
        if (pick < 92)
            return make_req(CMD_NOTE_ON, ch, nn, 7'd0);
        if (pick < 95)
            return make_req(CMD_UNUSED, ch, nn, NOTE_W'($urandom_range(0, 127)));
        if (pick < 97)
        begin
            held_keys.delete();
            return make_req(CMD_ALL_OFF, ch, nn, NOTE_W'($urandom_range(0, 127)));
        end
        ch = $urandom_range(0, 1) ? 4'd15 : 4'd0;
        nn = $urandom_range(0, 1) ? 7'd127 : 7'd0;
        held_keys.push_back({ch, nn});
        return make_req(CMD_NOTE_ON, ch, nn, $urandom_range(0, 1) ? 7'd127 : 7'd1);
    endfunction

    // Six phases of random traffic, writing the mode before each without
    // clearing; the last phase runs with no idling on either side
    task automatic test_random_traffic();
        logic phase_mode [0:5];
        phase_mode = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        for (int p = 0; p < 6; p++)
        begin
            write_mode(phase_mode[p]);
            bursts_on = (p != 5);
            for (int k = 0; k < 60; k++)
                send_request(random_request());
            settle();
        end
    endtask

    initial
    begin
        for (int i = 0; i < COUNT_DEPTH; i++)
            held_cnt[i] = '0;
        stack_used = 0;
        voices     = '0;
        mono_on    = 1'b0;

        // Hold every input at a known value through reset
        rst_n       <= 1'b0;
        note_valid  <= 1'b0;
        note_req    <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_mode(1'b0);
        test_poly_basics();
        test_mono_priority();
        test_mode_switch();
        test_count_ceiling();
        test_random_traffic();

        settle();
        while (pending_events.size() != 0)
            log_fault("event never delivered", pending_events.pop_front(), '0);

        $display("Drove %0d note requests and checked %0d engine events in poly and mono mode,",
                 requests_sent, events_checked);
        $display("including full stacks, mode changes mid-note and the held-count ceiling.");
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
